### src/wkec_pkg.sv
// Package for the windowed keyed event counter.
// Holds table sizes, status codes and the cell interface types; no dependencies.
package wkec_pkg;

	localparam int TableEntries = 64;
	localparam int IdxW = $clog2(TableEntries);

	typedef enum logic [1:0] {
		ST_HIT     = 2'd0,
		ST_INSERT  = 2'd1,
		ST_DROPPED = 2'd2,
		ST_QMISS   = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INC   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// Per-item broadcast from the controller to every cell.
	typedef struct packed {
		logic        lookup;
		logic [63:0] key;
	} cell_req_t;

	// Update broadcast to every cell, built from the registered lookup result.
	typedef struct packed {
		logic            touch;
		logic [IdxW-1:0] old_rank;
		logic            write;
		logic [IdxW-1:0] slot;
		logic [63:0]     key;
		logic [31:0]     epoch;
		logic [31:0]     cur;
		logic [31:0]     prev;
	} cell_upd_t;

	// Data handed from cell to cell along the chain.
	typedef struct packed {
		logic            found;
		logic [IdxW-1:0] hit;
		logic [31:0]     epoch;
		logic [31:0]     cur;
		logic [31:0]     prev;
		logic [IdxW-1:0] rank;
		logic            have_free;
		logic [IdxW-1:0] free_slot;
		logic [IdxW-1:0] free_rank;
		logic [IdxW-1:0] victim;
	} chain_t;

endpackage

### src/wkec_cell.sv
// One table entry: key, epoch, counts, recency rank and valid bit.
// Depends on wkec_pkg; joins the match chain from its lower neighbor.
module wkec_cell
	import wkec_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [IdxW-1:0] my_idx,
	input  cell_upd_t       upd,
	input  logic [63:0]     key_in,
	input  chain_t          chain_in,
	output chain_t          chain_out
);

	logic            valid_q;
	logic [63:0]     key_q;
	logic [31:0]     epoch_q;
	logic [31:0]     cur_q;
	logic [31:0]     prev_q;
	logic [IdxW-1:0] rank_q;
	logic            match;

	assign match = valid_q && (key_q == key_in);

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && match) begin
			chain_out.found = 1'b1;
			chain_out.hit   = my_idx;
			chain_out.epoch = epoch_q;
			chain_out.cur   = cur_q;
			chain_out.prev  = prev_q;
			chain_out.rank  = rank_q;
		end
		if (!valid_q && !chain_in.have_free) begin
			chain_out.have_free = 1'b1;
			chain_out.free_slot = my_idx;
			chain_out.free_rank = rank_q;
		end
		if (rank_q == IdxW'(TableEntries - 1)) begin
			chain_out.victim = my_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= my_idx;
		end else if (upd.touch) begin
			if (upd.slot == my_idx) begin
				rank_q <= '0;
			end else if (rank_q < upd.old_rank) begin
				rank_q <= rank_q + 1'b1;
			end
			if (upd.write && upd.slot == my_idx) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.touch && upd.write && upd.slot == my_idx) begin
			key_q   <= upd.key;
			epoch_q <= upd.epoch;
			cur_q   <= upd.cur;
			prev_q  <= upd.prev;
		end
	end

endmodule

### src/windowed_keyed_event_counter_top.sv
// Windowed keyed event counter: a chain of 64 table cells and a controller.
// Each item is a registered lookup along the cell chain, followed by the update of the table.
// The result is registered from the held lookup result; one item is in flight at a time,
// so a new item is accepted only once the previous result has been or is being taken.
// Reset empties the table, sets ranks to entry index, clears the insert counter and mode.
// Depends on wkec_pkg and wkec_cell.
module windowed_keyed_event_counter_top
	import wkec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [0:0]  cmd,
	input  logic [63:0] identity,
	input  logic [31:0] epoch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [32:0] window_count,
	output logic [63:0] distinct_inserted
);

	logic        mode_q;
	logic        busy_s1;
	logic        cmd_s1;
	logic [63:0] key_s1;
	logic [31:0] epoch_s1;
	chain_t      res_s1;
	logic [63:0] total_q;
	chain_t      chain [TableEntries+1];
	cell_upd_t   upd;
	logic [1:0]  st_d;
	logic [32:0] cnt_d;
	logic [31:0] gap;
	logic [31:0] rc;
	logic [31:0] rp;

	assign in_ready = !busy_s1 && (!out_valid || out_ready);

	assign chain[0] = '0;

	for (genvar g = 0; g < TableEntries; g++) begin : g_cell
		wkec_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_idx    (IdxW'(g)),
			.upd       (upd),
			.key_in    (identity),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1])
		);
	end

	always_comb begin
		gap = epoch_s1 - res_s1.epoch;
		rc  = res_s1.cur;
		rp  = res_s1.prev;
		if (gap == 32'd1) begin
			rp = res_s1.cur;
			rc = '0;
		end else if (gap != 32'd0) begin
			rp = '0;
			rc = '0;
		end
		upd          = '0;
		upd.key      = key_s1;
		upd.epoch    = epoch_s1;
		st_d         = ST_HIT;
		cnt_d        = '0;
		if (res_s1.found) begin
			if (cmd_s1 == CMD_INC && rc != 32'hFFFF_FFFF) begin
				rc = rc + 32'd1;
			end
			upd.touch    = busy_s1;
			upd.write    = 1'b1;
			upd.slot     = res_s1.hit;
			upd.old_rank = res_s1.rank;
			upd.cur      = rc;
			upd.prev     = rp;
			cnt_d        = {1'b0, rc} + {1'b0, rp};
		end else if (cmd_s1 == CMD_QUERY) begin
			st_d = ST_QMISS;
		end else if (!res_s1.have_free && mode_q) begin
			st_d = ST_DROPPED;
		end else begin
			st_d         = ST_INSERT;
			upd.touch    = busy_s1;
			upd.write    = 1'b1;
			upd.slot     = res_s1.have_free ? res_s1.free_slot : res_s1.victim;
			upd.old_rank = res_s1.have_free ? res_s1.free_rank : IdxW'(TableEntries - 1);
			upd.cur      = 32'd1;
			upd.prev     = '0;
			cnt_d        = 33'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			busy_s1   <= 1'b0;
			out_valid <= 1'b0;
			total_q   <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata[0];
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (busy_s1) begin
				busy_s1   <= 1'b0;
				out_valid <= 1'b1;
				if (st_d == ST_INSERT) begin
					total_q <= total_q + 64'd1;
				end
			end else if (in_valid && in_ready) begin
				busy_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= cmd[0];
			key_s1   <= identity;
			epoch_s1 <= epoch;
			res_s1   <= chain[TableEntries];
		end
		if (busy_s1) begin
			status            <= st_d;
			window_count      <= cnt_d;
			distinct_inserted <= (st_d == ST_INSERT) ? total_q + 64'd1 : total_q;
		end
	end

endmodule
